// File: rtl/tlc_pkg.sv
// shared constants, codes and control types of the two-level cache directory
package tlc_pkg;

  // default geometry limits
  localparam int L1_MAX_SETS_DEF = 64;
  localparam int L1_MAX_WAYS_DEF = 4;
  localparam int L2_MAX_SETS_DEF = 256;
  localparam int L2_MAX_WAYS_DEF = 8;

  // address width and tag store width
  localparam int AW = 32;
  localparam int TW = 32;
  // width of an effective way log2
  localparam int WLW = 3;

  // configuration register indexes
  localparam logic [2:0] REG_WRITE_ALLOCATE = 3'd0;
  localparam logic [2:0] REG_BLOCK_LOG2     = 3'd1;
  localparam logic [2:0] REG_L1_SET_LOG2    = 3'd2;
  localparam logic [2:0] REG_L1_WAY_LOG2    = 3'd3;
  localparam logic [2:0] REG_L2_SET_LOG2    = 3'd4;
  localparam logic [2:0] REG_L2_WAY_LOG2    = 3'd5;

  // row operations of one level
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_TOUCH = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_DROP  = 2'd3;

  // address source of a level
  localparam logic [1:0] SEL_IN  = 2'd0;
  localparam logic [1:0] SEL_A   = 2'd1;
  localparam logic [1:0] SEL_VA  = 2'd2;
  localparam logic [1:0] SEL_OLD = 2'd3;

  typedef struct packed {
    logic       take;
    logic       clr;
    logic       l1_rd;
    logic [1:0] l1_sel;
    logic [1:0] l1_op;
    logic       l1_dirty;
    logic       l2_rd;
    logic [1:0] l2_sel;
    logic [1:0] l2_op;
    logic       l2_dirty;
    logic       set_h1;
    logic       set_acc2;
    logic       set_h2;
    logic       set_dev;
    logic       set_bi;
  } tlc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic wr;
    logic wa;
    logic l1_hit;
    logic l1_vic_ev;
    logic l2_hit;
    logic l2_vic_valid;
  } tlc_stat_t;

endpackage

// File: rtl/tlc_level.sv
// one cache level: set memory, registered set row and the row update logic
module tlc_level #(
  parameter int SETS = 64,
  parameter int WAYS = 4,
  parameter int CLW  = 8,
  parameter int SW   = (SETS > 1) ? $clog2(SETS) : 1,
  parameter int CW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                      clk,
  input  logic                      clr_en,
  input  logic [CLW-1:0]            clr_idx,
  input  logic                      rd_en,
  input  logic [SW-1:0]             rd_set,
  input  logic [1:0]                op,
  input  logic                      op_dirty,
  input  logic [tlc_pkg::TW-1:0]    lk_tag,
  input  logic [tlc_pkg::WLW-1:0]   wlog,
  output logic                      hit,
  output logic                      vic_valid,
  output logic                      vic_dirty,
  output logic [tlc_pkg::TW-1:0]    vic_tag,
  output logic [SW-1:0]             row_set
);

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  // set memory, one row holds all ways of a set
  logic [WAYS-1:0][tlc_pkg::TW-1:0] tag_mem [SETS];
  logic [WAYS-1:0]                  val_mem [SETS];
  logic [WAYS-1:0]                  dty_mem [SETS];
  logic [WAYS-1:0][CW-1:0]          cnt_mem [SETS];

  logic [WAYS-1:0][tlc_pkg::TW-1:0] tag_r, tag_nxt;
  logic [WAYS-1:0]                  val_r, val_nxt;
  logic [WAYS-1:0]                  dty_r, dty_nxt;
  logic [WAYS-1:0][CW-1:0]          cnt_r, cnt_nxt;
  logic [SW-1:0]                    set_r;

  logic [WAYS-1:0] lane_en;
  logic [WW-1:0]   fway, vway, way;
  logic            vfound;
  logic [CW-1:0]   wmax, ref_cnt;

  assign wmax    = CW'((32'd1 << wlog) - 32'd1);
  assign row_set = set_r;

  // lookup and victim choice over the enabled ways
  always_comb begin
    hit    = 1'b0;
    fway   = '0;
    vfound = 1'b0;
    vway   = '0;
    for (int i = 0; i < WAYS; i++) begin
      lane_en[i] = ((32'(i) >> wlog) == 32'd0);
      if (lane_en[i] && !hit && val_r[i] && (tag_r[i] == lk_tag)) begin
        hit  = 1'b1;
        fway = WW'(i);
      end
      if (lane_en[i] && !vfound && (!val_r[i] || (cnt_r[i] == '0))) begin
        vfound = 1'b1;
        vway   = WW'(i);
      end
    end
  end

  assign way       = (op == tlc_pkg::OP_FILL) ? vway : fway;
  assign vic_valid = val_r[vway];
  assign vic_dirty = dty_r[vway];
  assign vic_tag   = tag_r[vway];
  assign ref_cnt   = cnt_r[way];

  // row update: lru aging of the other ways, then the chosen way
  always_comb begin
    tag_nxt = tag_r;
    val_nxt = val_r;
    dty_nxt = dty_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < WAYS; i++) begin
      if (WW'(i) != way && lane_en[i] && val_r[i]) begin
        if (op == tlc_pkg::OP_DROP) begin
          if (cnt_r[i] < ref_cnt) cnt_nxt[i] = cnt_r[i] + CW'(1);
        end else if (cnt_r[i] > ref_cnt) begin
          cnt_nxt[i] = cnt_r[i] - CW'(1);
        end
      end
    end
    unique case (op)
      tlc_pkg::OP_TOUCH: begin
        cnt_nxt[way] = wmax;
        val_nxt[way] = 1'b1;
        if (op_dirty) dty_nxt[way] = 1'b1;
      end
      tlc_pkg::OP_FILL: begin
        tag_nxt[way] = lk_tag;
        val_nxt[way] = 1'b1;
        dty_nxt[way] = op_dirty;
        cnt_nxt[way] = wmax;
      end
      tlc_pkg::OP_DROP: begin
        cnt_nxt[way] = '0;
        val_nxt[way] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // memory write port: clearing pass or row write-back
  always_ff @(posedge clk) begin
    if (clr_en) begin
      if (32'(clr_idx) < 32'(SETS)) begin
        tag_mem[clr_idx[SW-1:0]] <= '0;
        val_mem[clr_idx[SW-1:0]] <= '0;
        dty_mem[clr_idx[SW-1:0]] <= '0;
        cnt_mem[clr_idx[SW-1:0]] <= '0;
      end
    end else if (op != tlc_pkg::OP_NONE) begin
      tag_mem[set_r] <= tag_nxt;
      val_mem[set_r] <= val_nxt;
      dty_mem[set_r] <= dty_nxt;
      cnt_mem[set_r] <= cnt_nxt;
    end
  end

  // memory read port with registered row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_r <= tag_mem[rd_set];
      val_r <= val_mem[rd_set];
      dty_r <= dty_mem[rd_set];
      cnt_r <= cnt_mem[rd_set];
      set_r <= rd_set;
    end
  end

endmodule

// File: rtl/tlc_datapath.sv
// datapath: config registers, address fields, both levels and result flags
module tlc_datapath #(
  parameter int L1_MAX_SETS = tlc_pkg::L1_MAX_SETS_DEF,
  parameter int L1_MAX_WAYS = tlc_pkg::L1_MAX_WAYS_DEF,
  parameter int L2_MAX_SETS = tlc_pkg::L2_MAX_SETS_DEF,
  parameter int L2_MAX_WAYS = tlc_pkg::L2_MAX_WAYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlc_pkg::tlc_cmd_t    cmd,
  output tlc_pkg::tlc_stat_t   stat,
  input  logic [39:0]          in_tdata,
  output logic [7:0]           out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [3:0]           cfg_wdata
);

  localparam int MAXS  = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
  localparam int CLW   = (MAXS > 1) ? $clog2(MAXS) : 1;
  localparam int S1W   = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int S2W   = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int S1FL  = $clog2(L1_MAX_SETS + 1) - 1;
  localparam int S2FL  = $clog2(L2_MAX_SETS + 1) - 1;
  localparam int W1FL  = $clog2(L1_MAX_WAYS + 1) - 1;
  localparam int W2FL  = $clog2(L2_MAX_WAYS + 1) - 1;

  // configuration registers
  logic       wa_r;
  logic [3:0] blk_r;
  logic [2:0] l1s_r;
  logic [1:0] l1w_r;
  logic [3:0] l2s_r;
  logic [1:0] l2w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r  <= 1'b1;
      blk_r <= 4'd6;
      l1s_r <= 3'd6;
      l1w_r <= 2'd2;
      l2s_r <= 4'd8;
      l2w_r <= 2'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tlc_pkg::REG_WRITE_ALLOCATE: wa_r  <= cfg_wdata[0];
        tlc_pkg::REG_BLOCK_LOG2:     blk_r <= cfg_wdata;
        tlc_pkg::REG_L1_SET_LOG2:    l1s_r <= cfg_wdata[2:0];
        tlc_pkg::REG_L1_WAY_LOG2:    l1w_r <= cfg_wdata[1:0];
        tlc_pkg::REG_L2_SET_LOG2:    l2s_r <= cfg_wdata;
        tlc_pkg::REG_L2_WAY_LOG2:    l2w_r <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // geometry clamped to the storage limits
  logic [4:0]              slog1, slog2;
  logic [tlc_pkg::WLW-1:0] wlog1, wlog2;

  assign slog1 = (32'(l1s_r) > 32'(S1FL)) ? 5'(S1FL) : 5'(l1s_r);
  assign slog2 = (32'(l2s_r) > 32'(S2FL)) ? 5'(S2FL) : 5'(l2s_r);
  assign wlog1 = (32'(l1w_r) > 32'(W1FL)) ? tlc_pkg::WLW'(W1FL) : tlc_pkg::WLW'(l1w_r);
  assign wlog2 = (32'(l2w_r) > 32'(W2FL)) ? tlc_pkg::WLW'(W2FL) : tlc_pkg::WLW'(l2w_r);

  // access registers and captured victim line addresses
  logic                   wr_r;
  logic [tlc_pkg::AW-1:0] a_r, va_r, old_r;
  logic                   h1_r, acc2_r, h2_r, dev_r, bi_r;
  logic [CLW-1:0]         clr_r;

  logic [tlc_pkg::AW-1:0] a1, a2;

  always_comb begin
    unique case (cmd.l1_sel)
      tlc_pkg::SEL_IN:  a1 = in_tdata[32:1];
      tlc_pkg::SEL_A:   a1 = a_r;
      tlc_pkg::SEL_VA:  a1 = va_r;
      tlc_pkg::SEL_OLD: a1 = old_r;
      default:          a1 = a_r;
    endcase
    unique case (cmd.l2_sel)
      tlc_pkg::SEL_IN:  a2 = in_tdata[32:1];
      tlc_pkg::SEL_A:   a2 = a_r;
      tlc_pkg::SEL_VA:  a2 = va_r;
      tlc_pkg::SEL_OLD: a2 = old_r;
      default:          a2 = a_r;
    endcase
  end

  // set index and tag of each level's address
  logic [31:0]            mask1, mask2, s1_full, s2_full;
  logic [S1W-1:0]         set1;
  logic [S2W-1:0]         set2;
  logic [tlc_pkg::TW-1:0] tag1, tag2;

  assign mask1   = (32'd1 << slog1) - 32'd1;
  assign mask2   = (32'd1 << slog2) - 32'd1;
  assign s1_full = (a1 >> blk_r) & mask1;
  assign s2_full = (a2 >> blk_r) & mask2;
  assign set1    = s1_full[S1W-1:0];
  assign set2    = s2_full[S2W-1:0];
  assign tag1    = a1 >> (6'(blk_r) + 6'(slog1));
  assign tag2    = a2 >> (6'(blk_r) + 6'(slog2));

  logic                   l1_hit, l1_vv, l1_vd, l2_hit, l2_vv, l2_vd;
  logic [tlc_pkg::TW-1:0] l1_vt, l2_vt;
  logic [S1W-1:0]         l1_rs;
  logic [S2W-1:0]         l2_rs;

  tlc_level #(.SETS(L1_MAX_SETS), .WAYS(L1_MAX_WAYS), .CLW(CLW)) u_l1 (
    .clk      (clk),
    .clr_en   (cmd.clr),
    .clr_idx  (clr_r),
    .rd_en    (cmd.l1_rd),
    .rd_set   (set1),
    .op       (cmd.l1_op),
    .op_dirty (cmd.l1_dirty),
    .lk_tag   (tag1),
    .wlog     (wlog1),
    .hit      (l1_hit),
    .vic_valid(l1_vv),
    .vic_dirty(l1_vd),
    .vic_tag  (l1_vt),
    .row_set  (l1_rs)
  );

  tlc_level #(.SETS(L2_MAX_SETS), .WAYS(L2_MAX_WAYS), .CLW(CLW)) u_l2 (
    .clk      (clk),
    .clr_en   (cmd.clr),
    .clr_idx  (clr_r),
    .rd_en    (cmd.l2_rd),
    .rd_set   (set2),
    .op       (cmd.l2_op),
    .op_dirty (cmd.l2_dirty),
    .lk_tag   (tag2),
    .wlog     (wlog2),
    .hit      (l2_hit),
    .vic_valid(l2_vv),
    .vic_dirty(l2_vd),
    .vic_tag  (l2_vt),
    .row_set  (l2_rs)
  );

  // rebuilt byte addresses of the victims
  logic [tlc_pkg::AW-1:0] l1_line, l2_line;

  assign l1_line = ((l1_vt << slog1) | 32'(l1_rs)) << blk_r;
  assign l2_line = ((l2_vt << slog2) | 32'(l2_rs)) << blk_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      wr_r <= in_tdata[0];
      a_r  <= in_tdata[32:1];
    end
    if (cmd.l2_op == tlc_pkg::OP_FILL) va_r <= l2_line;
    if (cmd.l1_op == tlc_pkg::OP_FILL) old_r <= l1_line;
  end

  // result flags, cleared at each accepted access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r   <= 1'b0;
      acc2_r <= 1'b0;
      h2_r   <= 1'b0;
      dev_r  <= 1'b0;
      bi_r   <= 1'b0;
    end else if (cmd.take) begin
      h1_r   <= 1'b0;
      acc2_r <= 1'b0;
      h2_r   <= 1'b0;
      dev_r  <= 1'b0;
      bi_r   <= 1'b0;
    end else begin
      if (cmd.set_h1)   h1_r   <= 1'b1;
      if (cmd.set_acc2) acc2_r <= 1'b1;
      if (cmd.set_h2)   h2_r   <= 1'b1;
      if (cmd.set_dev)  dev_r  <= 1'b1;
      if (cmd.set_bi)   bi_r   <= 1'b1;
    end
  end

  // clearing pass row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + CLW'(1);
    end
  end

  assign stat.clr_last     = (32'(clr_r) == 32'(MAXS - 1));
  assign stat.wr           = wr_r;
  assign stat.wa           = wa_r;
  assign stat.l1_hit       = l1_hit;
  assign stat.l1_vic_ev    = l1_vv && l1_vd;
  assign stat.l2_hit       = l2_hit;
  assign stat.l2_vic_valid = l2_vv;

  assign out_tdata = {3'b000, bi_r, dev_r, h2_r, acc2_r, h1_r};

endmodule

// File: rtl/tlc_ctrl.sv
// controller: sequences lookups, evictions and fills of one access
module tlc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  tlc_pkg::tlc_stat_t stat,
  output tlc_pkg::tlc_cmd_t  cmd
);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOOK  = 4'd2;
  localparam logic [3:0] ST_RDBI  = 4'd3;
  localparam logic [3:0] ST_BI    = 4'd4;
  localparam logic [3:0] ST_RD1   = 4'd5;
  localparam logic [3:0] ST_FILL1 = 4'd6;
  localparam logic [3:0] ST_RD2   = 4'd7;
  localparam logic [3:0] ST_WB    = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  // command decode and next state
  always_comb begin
    cmd       = '0;
    cmd.l1_sel = tlc_pkg::SEL_A;
    cmd.l2_sel = tlc_pkg::SEL_A;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.l1_sel = tlc_pkg::SEL_IN;
        cmd.l2_sel = tlc_pkg::SEL_IN;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          cmd.l1_rd = 1'b1;
          cmd.l2_rd = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (stat.l1_hit) begin
          cmd.l1_op    = tlc_pkg::OP_TOUCH;
          cmd.l1_dirty = stat.wr;
          cmd.set_h1   = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          cmd.set_acc2 = 1'b1;
          if (stat.l2_hit) begin
            cmd.l2_op    = tlc_pkg::OP_TOUCH;
            cmd.l2_dirty = stat.wr && !stat.wa;
            cmd.set_h2   = 1'b1;
            state_nxt    = (stat.wr && !stat.wa) ? ST_OUT : ST_RD1;
          end else if (!stat.wr || stat.wa) begin
            cmd.l2_op = tlc_pkg::OP_FILL;
            state_nxt = stat.l2_vic_valid ? ST_RDBI : ST_RD1;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_RDBI: begin
        cmd.l1_sel = tlc_pkg::SEL_VA;
        cmd.l1_rd  = 1'b1;
        state_nxt  = ST_BI;
      end
      ST_BI: begin
        cmd.l1_sel = tlc_pkg::SEL_VA;
        if (stat.l1_hit) begin
          cmd.l1_op  = tlc_pkg::OP_DROP;
          cmd.set_bi = 1'b1;
        end
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.l1_rd = 1'b1;
        state_nxt = ST_FILL1;
      end
      ST_FILL1: begin
        cmd.l1_op    = tlc_pkg::OP_FILL;
        cmd.l1_dirty = stat.wr;
        if (stat.l1_vic_ev) begin
          cmd.set_dev = 1'b1;
          state_nxt   = ST_RD2;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_RD2: begin
        cmd.l2_sel = tlc_pkg::SEL_OLD;
        cmd.l2_rd  = 1'b1;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        cmd.l2_sel = tlc_pkg::SEL_OLD;
        if (stat.l2_hit) begin
          cmd.l2_op    = tlc_pkg::OP_TOUCH;
          cmd.l2_dirty = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/two_level_inclusive_lru_cache_top.sv
// Two-level inclusive LRU cache directory. After reset a clearing pass over
// max(L1_MAX_SETS, L2_MAX_SETS) rows (256 by default) zeroes both set
// memories; no access is taken meanwhile. Each access looks up both levels
// and ends on an L1 hit or an L2 write-around; otherwise L2 eviction with
// back-invalidation probe, L1 fill and dirty write-back into L2 follow as
// needed; the result may wait for out_tready. Each step is one read-modify-write
// of a whole set row through the single read and write port of a level's
// set memory. One access is in flight at a time. Configuration writes take
// effect at once; the user is to write them between accesses (not enforced).
module two_level_inclusive_lru_cache_top #(
  parameter int L1_MAX_SETS = tlc_pkg::L1_MAX_SETS_DEF,
  parameter int L1_MAX_WAYS = tlc_pkg::L1_MAX_WAYS_DEF,
  parameter int L2_MAX_SETS = tlc_pkg::L2_MAX_SETS_DEF,
  parameter int L2_MAX_WAYS = tlc_pkg::L2_MAX_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation, address, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // l1_hit, l2_accessed, l2_hit, l1_dirty_evicted,
                                  // back_invalidated, zero pad
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);

  tlc_pkg::tlc_cmd_t  cmd;
  tlc_pkg::tlc_stat_t stat;

  tlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlc_datapath #(
    .L1_MAX_SETS(L1_MAX_SETS),
    .L1_MAX_WAYS(L1_MAX_WAYS),
    .L2_MAX_SETS(L2_MAX_SETS),
    .L2_MAX_WAYS(L2_MAX_WAYS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_tdata (in_tdata),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

endmodule

// File: rtl/tlc_checker.sv
// port checker of the cache directory and its bind to the top level
module tlc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // one access in flight: no input transfer while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result is pending");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // l2 is consulted exactly on an l1 miss, and hits only when consulted
  a_level_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] != out_tdata[1]) && !(out_tdata[2] && !out_tdata[1]))
    else $error("inconsistent level flags");

  // back-invalidation only comes from an l2 miss
  a_bi_on_l2_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[1] && !out_tdata[2])
    else $error("back-invalidation without an l2 miss");

endmodule

bind two_level_inclusive_lru_cache_top tlc_checker u_tlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
